### design/swtb_pkg.sv
`timescale 1ns / 1ps

package swtb_pkg;

    // Bank size; timers 0..7 are reachable from the ports.
    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MASK_W     = 8;
    localparam int PAD_W      = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;
    localparam int TIME_W     = 32;
    localparam int HALF_W     = 16;

    typedef enum logic
    {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [0:0]        kind;
        logic [15:0]       counter_low;
        logic [2:0]        timer_index;
        logic [TIME_W-1:0] interval_ticks;
    } swtb_item_t;

    typedef struct packed
    {
        logic [MASK_W-1:0] running_mask;
        logic [MASK_W-1:0] expired_mask;
        logic [TIME_W-1:0] current_time;
    } swtb_result_t;

endpackage

### design/software_timer_bank.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS one-shot timers on a 32-bit time base ({extension count,
// sampled 16-bit counter}). A start transfer loads a timer's interval, takes the
// current time as its reference and sets it running; a tick transfer bumps the
// extension count, rebuilds the time and checks every running timer, stopping
// those whose elapsed time (mod 2^32) is greater than the interval. Each input
// transfer yields exactly one result transfer with the running mask, the timers
// that expired on it, and the time. A start goes from idle straight to the
// finish state; a tick steps one subtract/compare unit through the timer
// table one entry per cycle via a registered table read, then passes a last
// state before finishing. The input is ready only while the sequencer is idle;
// a finished result waits in the output register and does not block the next
// input transfer, only the next result load.
module software_timer_bank
    import swtb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  swtb_item_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output swtb_result_t result
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [HALF_W-1:0]     ext_reg, ext_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] expired_reg, expired_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  result_valid_reg, result_valid_next;
    swtb_result_t          result_reg, result_next;

    // timer table: interval and reference per timer, registered reads
    logic [TIME_W-1:0] interval_mem [NUM_TIMERS];
    logic [TIME_W-1:0] reference_mem [NUM_TIMERS];
    logic [TIME_W-1:0] ivl_rd_reg;
    logic [TIME_W-1:0] ref_rd_reg;

    logic             accept;
    logic             start_write;
    logic [IDX_W-1:0] start_addr;
    logic             hit;
    logic             load_result;
    logic [PAD_W-1:0] running_pad;
    logic [PAD_W-1:0] expired_pad;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign start_addr   = IDX_W'(item.timer_index);
    // starts beyond the bank are dropped
    assign start_write  = accept && (item.kind == KIND_START)
                          && (32'(item.timer_index) < NUM_TIMERS);
    assign load_result  = (state_reg == S_FINISH) && (!result_valid_reg || result_ready);
    assign running_pad  = PAD_W'(running_reg);
    assign expired_pad  = PAD_W'(expired_reg);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    swtb_expiry_unit u_expiry
    (
        .time_now  (time_reg),
        .reference (ref_rd_reg),
        .interval  (ivl_rd_reg),
        .expired   (hit)
    );

    always_ff @(posedge clk)
    begin
        if (start_write)
        begin
            interval_mem[start_addr]  <= item.interval_ticks;
            reference_mem[start_addr] <= time_reg;
        end
        ivl_rd_reg <= interval_mem[scan_idx_reg];
        ref_rd_reg <= reference_mem[scan_idx_reg];
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        ext_next          = ext_reg;
        time_next         = time_reg;
        running_next      = running_reg;
        expired_next      = expired_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_valid_next    = 1'b0;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        // compare stage, fed by the registered table read
        if (cmp_valid_reg && running_reg[cmp_idx_reg] && hit)
        begin
            running_next[cmp_idx_reg] = 1'b0;
            expired_next[cmp_idx_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    expired_next = '0;
                    if (item.kind == KIND_TICK)
                    begin
                        ext_next      = ext_reg + 1'b1;
                        time_next     = {ext_reg + 1'b1, item.counter_low};
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        if (start_write)
                        begin
                            running_next[start_addr] = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg;
                if (scan_idx_reg == IDX_W'(NUM_TIMERS - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_result)
                begin
                    result_next.running_mask = running_pad[MASK_W-1:0];
                    result_next.expired_mask = expired_pad[MASK_W-1:0];
                    result_next.current_time = time_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ext_reg          <= '0;
            time_reg         <= '0;
            running_reg      <= '0;
            expired_reg      <= '0;
            scan_idx_reg     <= '0;
            cmp_idx_reg      <= '0;
            cmp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ext_reg          <= ext_next;
            time_reg         <= time_next;
            running_reg      <= running_next;
            expired_reg      <= expired_next;
            scan_idx_reg     <= scan_idx_next;
            cmp_idx_reg      <= cmp_idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

### design/swtb_expiry_unit.sv
`timescale 1ns / 1ps

// Shared elapsed-time check: (now - ref) mod 2^32 > interval.
module swtb_expiry_unit
    import swtb_pkg::*;
(
    input  logic [TIME_W-1:0] time_now,
    input  logic [TIME_W-1:0] reference,
    input  logic [TIME_W-1:0] interval,
    output logic              expired
);

    logic [TIME_W-1:0] elapsed;

    assign elapsed = time_now - reference;
    assign expired = elapsed > interval;

endmodule
